FILE: hw/rtl/spp_pkg.sv
package spp_pkg;

   localparam int MAX_RHYTHMS_DEF = 8;
   localparam int MAX_STEPS_DEF   = 256;

   localparam logic [1:0] MODE_TICK   = 2'd0;
   localparam logic [1:0] MODE_WRITE  = 2'd1;
   localparam logic [1:0] MODE_COMMIT = 2'd2;

   localparam logic [1:0] REG_MASTER_LOOP = 2'd0;
   localparam logic [1:0] REG_ACTIVE      = 2'd1;

   localparam int DIV_NUM_W = 31;
   localparam int DIV_DEN_W = 16;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [31:0] global_step;
      logic [2:0]         rhythm;
      logic [7:0]         step;
      logic               hit;
      logic               accent;
      logic [8:0]         length;
      logic [8:0]         accent_length;
      logic               restart;
   } req_type;

   typedef struct packed {
      logic [7:0]  fired_mask;
      logic [7:0]  accent_mask;
      logic [7:0]  tied_mask;
      logic [7:0]  rhythm_wrap_mask;
      logic        master_wrapped;
      logic [15:0] master_step;
   } rsp_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] dividend;
      logic [DIV_DEN_W-1:0] divisor;
   } div_req_type;

endpackage

FILE: hw/rtl/spp_ram.sv
module spp_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: hw/rtl/spp_mod_unit.sv
module spp_mod_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  spp_pkg::div_req_type           req,
   output logic                           done,
   output logic [spp_pkg::DIV_DEN_W-1:0]  rem
);

   localparam int NW = spp_pkg::DIV_NUM_W;
   localparam int DW = spp_pkg::DIV_DEN_W;
   localparam int CW = $clog2(NW);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0] num_ff, num_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] den_ff, den_in;
   logic [DW:0]   trial;

   assign trial = {rem_ff, num_ff[NW-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(NW - 1);
         num_in  = req.dividend;
         rem_in  = '0;
         den_in  = req.divisor;
      end else if (busy_ff) begin
         num_in = num_ff << 1;
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DW'(trial - {1'b0, den_ff});
         end else begin
            rem_in = trial[DW-1:0];
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

FILE: hw/rtl/step_pattern_playback_unit.sv
// Pattern write and commit beats are taken in idle, ready again next cycle.
// Tick: accept, a master modulo when looping is on, then per active track a
// track step, plus for a nonempty track a step modulo and, when it moved or is
// new, an accent modulo when an accent length is set and a read and event step
// per step walked (one on a first play), then load the result, held until
// taken. One beat at a time. Reset (synchronous) clears control registers and
// track state; pattern RAMs are not cleared and read undefined until written.
module step_pattern_playback_unit #(
   parameter int MAX_RHYTHMS = spp_pkg::MAX_RHYTHMS_DEF,
   parameter int MAX_STEPS   = spp_pkg::MAX_STEPS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  spp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output spp_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_data
);

   localparam int RW = (MAX_RHYTHMS > 1) ? $clog2(MAX_RHYTHMS) : 1;
   localparam int SW = $clog2(MAX_STEPS);
   localparam int LW = $clog2(MAX_STEPS + 1);
   localparam int DEPTH = MAX_RHYTHMS * MAX_STEPS;
   localparam int AW = $clog2(DEPTH);
   localparam int NW = spp_pkg::DIV_NUM_W;
   localparam int DW = spp_pkg::DIV_DEN_W;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MDIV = 3'd1;
   localparam logic [2:0] ST_TRK  = 3'd2;
   localparam logic [2:0] ST_TDIV = 3'd3;
   localparam logic [2:0] ST_ADIV = 3'd4;
   localparam logic [2:0] ST_RD   = 3'd5;
   localparam logic [2:0] ST_EV   = 3'd6;
   localparam logic [2:0] ST_FIN  = 3'd7;

   logic [2:0]    state_ff, state_in;
   logic [RW-1:0] r_ff, r_in;
   logic [NW-1:0] eff_ff, eff_in;
   logic [NW-1:0] last_master_ff, last_master_in;
   logic          have_ff, have_in;
   logic [15:0]   master_ff, master_in;
   logic [3:0]    active_ff, active_in;
   logic [SW-1:0] cur_ff, cur_in;
   logic [SW-1:0] s_ff, s_in;
   logic [SW-1:0] a_ff, a_in;
   logic          walk_ff, walk_in;
   logic [7:0]    fired_ff, fired_in;
   logic [7:0]    acc_ff, acc_in;
   logic [7:0]    tied_ff, tied_in;
   logic [7:0]    wrap_ff, wrap_in;
   logic          mwrap_ff, mwrap_in;
   logic [15:0]   mstep_ff, mstep_in;
   logic          rsp_valid_ff, rsp_valid_in;
   spp_pkg::rsp_type     rsp_ff, rsp_in;
   spp_pkg::div_req_type div_req_ff, div_req_in;

   logic [LW-1:0] len_ff   [MAX_RHYTHMS];
   logic [LW-1:0] len_in   [MAX_RHYTHMS];
   logic [LW-1:0] alen_ff  [MAX_RHYTHMS];
   logic [LW-1:0] alen_in  [MAX_RHYTHMS];
   logic [SW-1:0] last_ff  [MAX_RHYTHMS];
   logic [SW-1:0] last_in  [MAX_RHYTHMS];
   logic [MAX_RHYTHMS-1:0] never_ff, never_in;
   logic [MAX_RHYTHMS-1:0] phit_ff, phit_in;
   logic [MAX_RHYTHMS-1:0] pend_ff, pend_in;

   logic          div_done;
   logic [DW-1:0] div_rem;

   logic          req_fire;
   logic          mem_we;
   logic [AW-1:0] wr_addr, hit_addr, acc_addr;
   logic          hit_rd, acc_rd;
   logic [LW-1:0] len_r, alen_r;
   logic [SW-1:0] cur_div, prv_sel;
   logic [LW-1:0] prv_p1, s_p1, a_p1;
   logic [SW-1:0] s_start;
   logic [7:0]    rbit;
   logic [3:0]    n_new;
   logic [4:0]    r_p1;
   logic [LW-1:0] len_sat, alen_sat;
   logic          h_bit, a_bit;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;

   assign len_r   = len_ff[r_ff];
   assign alen_r  = alen_ff[r_ff];
   assign cur_div = div_rem[SW-1:0];
   assign rbit    = 8'(9'd1 << r_ff);
   assign r_p1    = 5'(r_ff) + 5'd1;
   assign h_bit   = hit_rd;
   assign a_bit   = acc_rd && (alen_r != '0);

   assign prv_sel = (pend_ff[r_ff] && !never_ff[r_ff]) ? cur_div : last_ff[r_ff];
   assign prv_p1  = LW'(prv_sel) + LW'(1);
   assign s_start = never_ff[r_ff] ? cur_div :
                    ((prv_p1 == len_r) ? '0 : prv_p1[SW-1:0]);
   assign s_p1    = LW'(s_ff) + LW'(1);
   assign a_p1    = LW'(a_ff) + LW'(1);

   assign len_sat  = ({2'b0, req_data.length} > 11'(MAX_STEPS)) ?
                     LW'(MAX_STEPS) : LW'(req_data.length);
   assign alen_sat = ({2'b0, req_data.accent_length} > 11'(MAX_STEPS)) ?
                     LW'(MAX_STEPS) : LW'(req_data.accent_length);
   assign n_new    = ({1'b0, csr_data[3:0]} > 5'(MAX_RHYTHMS)) ?
                     4'(MAX_RHYTHMS) : csr_data[3:0];

   assign wr_addr  = AW'(int'(req_data.rhythm) * MAX_STEPS + int'(req_data.step));
   assign mem_we   = req_fire && (req_data.mode == spp_pkg::MODE_WRITE) &&
                     ({1'b0, req_data.rhythm} < active_ff) &&
                     ({3'b0, req_data.step} < 11'(MAX_STEPS));
   assign hit_addr = (state_ff == ST_IDLE) ? wr_addr :
                     AW'(int'(r_ff) * MAX_STEPS + int'(s_ff));
   assign acc_addr = (state_ff == ST_IDLE) ? wr_addr :
                     AW'(int'(r_ff) * MAX_STEPS + int'(a_ff));

   spp_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_hit_ram (
      .clock (clock),
      .we    (mem_we),
      .addr  (hit_addr),
      .wdata (req_data.hit),
      .rdata (hit_rd)
   );

   spp_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_acc_ram (
      .clock (clock),
      .we    (mem_we),
      .addr  (acc_addr),
      .wdata (req_data.accent),
      .rdata (acc_rd)
   );

   spp_mod_unit u_mod (
      .clock (clock),
      .reset (reset),
      .req   (div_req_ff),
      .done  (div_done),
      .rem   (div_rem)
   );

   always_comb begin
      state_in       = state_ff;
      r_in           = r_ff;
      eff_in         = eff_ff;
      last_master_in = last_master_ff;
      have_in        = have_ff;
      master_in      = master_ff;
      active_in      = active_ff;
      cur_in         = cur_ff;
      s_in           = s_ff;
      a_in           = a_ff;
      walk_in        = walk_ff;
      fired_in       = fired_ff;
      acc_in         = acc_ff;
      tied_in        = tied_ff;
      wrap_in        = wrap_ff;
      mwrap_in       = mwrap_ff;
      mstep_in       = mstep_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_in         = rsp_ff;
      div_req_in       = div_req_ff;
      div_req_in.start = 1'b0;
      len_in   = len_ff;
      alen_in  = alen_ff;
      last_in  = last_ff;
      never_in = never_ff;
      phit_in  = phit_ff;
      pend_in  = pend_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid && csr_ready) begin
         if (csr_index == spp_pkg::REG_MASTER_LOOP) begin
            master_in = csr_data;
         end else if (csr_index == spp_pkg::REG_ACTIVE) begin
            for (int i = 0; i < MAX_RHYTHMS; i++) begin
               if (5'(i) >= {1'b0, n_new} && 5'(i) < {1'b0, active_ff}) begin
                  len_in[i]   = '0;
                  alen_in[i]  = '0;
                  last_in[i]  = '0;
                  never_in[i] = 1'b1;
                  phit_in[i]  = 1'b0;
                  pend_in[i]  = 1'b0;
               end
            end
            active_in = n_new;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_data.mode == spp_pkg::MODE_COMMIT) begin
                  if ({1'b0, req_data.rhythm} < active_ff) begin
                     len_in[RW'(req_data.rhythm)]  = len_sat;
                     alen_in[RW'(req_data.rhythm)] = alen_sat;
                     pend_in[RW'(req_data.rhythm)] = 1'b1;
                     if (req_data.restart) begin
                        never_in[RW'(req_data.rhythm)] = 1'b1;
                     end
                  end
               end else if (req_data.mode == spp_pkg::MODE_TICK) begin
                  fired_in = '0;
                  acc_in   = '0;
                  tied_in  = '0;
                  wrap_in  = '0;
                  mwrap_in = 1'b0;
                  mstep_in = '0;
                  r_in     = '0;
                  eff_in   = req_data.global_step[31] ? '0 : req_data.global_step[30:0];
                  if (active_ff == '0) begin
                     state_in = ST_FIN;
                  end else if (master_ff != '0) begin
                     div_req_in.start    = 1'b1;
                     div_req_in.dividend = req_data.global_step[31] ? '0 :
                                           req_data.global_step[30:0];
                     div_req_in.divisor  = master_ff;
                     state_in = ST_MDIV;
                  end else begin
                     last_master_in = req_data.global_step[31] ? '0 :
                                      req_data.global_step[30:0];
                     have_in  = 1'b1;
                     state_in = ST_TRK;
                  end
               end
            end
         end
         ST_MDIV: begin
            if (div_done) begin
               eff_in         = NW'(div_rem);
               mwrap_in       = have_ff && (NW'(div_rem) < last_master_ff);
               mstep_in       = div_rem;
               last_master_in = NW'(div_rem);
               have_in        = 1'b1;
               state_in       = ST_TRK;
            end
         end
         ST_TRK: begin
            if (len_r == '0) begin
               pend_in[r_ff] = 1'b0;
               if (r_p1 == {1'b0, active_ff}) begin
                  state_in = ST_FIN;
               end else begin
                  r_in = RW'(r_p1);
               end
            end else begin
               div_req_in.start    = 1'b1;
               div_req_in.dividend = eff_ff;
               div_req_in.divisor  = DW'(len_r);
               state_in = ST_TDIV;
            end
         end
         ST_TDIV: begin
            if (div_done) begin
               cur_in        = cur_div;
               pend_in[r_ff] = 1'b0;
               walk_in       = !never_ff[r_ff];
               s_in          = s_start;
               if (!never_ff[r_ff] && cur_div == prv_sel) begin
                  last_in[r_ff] = cur_div;
                  if (r_p1 == {1'b0, active_ff}) begin
                     state_in = ST_FIN;
                  end else begin
                     r_in     = RW'(r_p1);
                     state_in = ST_TRK;
                  end
               end else if (alen_r != '0) begin
                  div_req_in.start    = 1'b1;
                  div_req_in.dividend = NW'(s_start);
                  div_req_in.divisor  = DW'(alen_r);
                  state_in = ST_ADIV;
               end else begin
                  a_in     = '0;
                  state_in = ST_RD;
               end
            end
         end
         ST_ADIV: begin
            if (div_done) begin
               a_in     = div_rem[SW-1:0];
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            state_in = ST_EV;
         end
         ST_EV: begin
            if (walk_ff && s_ff == '0) begin
               wrap_in = wrap_ff | rbit;
            end
            if (h_bit) begin
               fired_in = fired_ff | rbit;
               acc_in   = a_bit ? (acc_ff | rbit) : (acc_ff & ~rbit);
               if (walk_ff) begin
                  tied_in = phit_ff[r_ff] ? (tied_ff | rbit) : (tied_ff & ~rbit);
               end
            end
            phit_in[r_ff] = h_bit;
            if (!walk_ff || s_ff == cur_ff) begin
               last_in[r_ff]  = cur_ff;
               never_in[r_ff] = 1'b0;
               if (r_p1 == {1'b0, active_ff}) begin
                  state_in = ST_FIN;
               end else begin
                  r_in     = RW'(r_p1);
                  state_in = ST_TRK;
               end
            end else begin
               s_in     = (s_p1 == len_r) ? '0 : s_p1[SW-1:0];
               a_in     = ((s_p1 == len_r) || (a_p1 == alen_r)) ? '0 : a_p1[SW-1:0];
               state_in = ST_RD;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.fired_mask       = fired_ff;
               rsp_in.accent_mask      = acc_ff;
               rsp_in.tied_mask        = tied_ff;
               rsp_in.rhythm_wrap_mask = wrap_ff;
               rsp_in.master_wrapped   = mwrap_ff;
               rsp_in.master_step      = mstep_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         r_ff           <= '0;
         last_master_ff <= '0;
         have_ff        <= 1'b0;
         master_ff      <= '0;
         active_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
         div_req_ff     <= '0;
         for (int i = 0; i < MAX_RHYTHMS; i++) begin
            len_ff[i]  <= '0;
            alen_ff[i] <= '0;
            last_ff[i] <= '0;
         end
         never_ff <= '1;
         phit_ff  <= '0;
         pend_ff  <= '0;
      end else begin
         state_ff       <= state_in;
         r_ff           <= r_in;
         last_master_ff <= last_master_in;
         have_ff        <= have_in;
         master_ff      <= master_in;
         active_ff      <= active_in;
         rsp_valid_ff   <= rsp_valid_in;
         div_req_ff     <= div_req_in;
         len_ff   <= len_in;
         alen_ff  <= alen_in;
         last_ff  <= last_in;
         never_ff <= never_in;
         phit_ff  <= phit_in;
         pend_ff  <= pend_in;
      end
      eff_ff   <= eff_in;
      cur_ff   <= cur_in;
      s_ff     <= s_in;
      a_ff     <= a_in;
      walk_ff  <= walk_in;
      fired_ff <= fired_in;
      acc_ff   <= acc_in;
      tied_ff  <= tied_in;
      wrap_ff  <= wrap_in;
      mwrap_ff <= mwrap_in;
      mstep_ff <= mstep_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_MDIV || state_ff == ST_TDIV || state_ff == ST_ADIV))
      else $error("remainder unit finished outside a wait state");

   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EV) |-> (LW'(s_ff) < len_r))
      else $error("walk step beyond track length");

   a_accent_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD) |-> (alen_r == '0 || LW'(a_ff) < alen_r))
      else $error("accent index beyond accent length");
`endif

endmodule
